[rtl/core/mpsrb_pkg.sv]
package mpsrb_pkg;

    // default configuration
    localparam int NUM_PORTS_DEF = 5;
    localparam int RX_DEPTH_DEF  = 256;
    localparam int TX_DEPTH_DEF  = 256;

    // item operation codes
    typedef enum logic [2:0] {
        OP_OPEN      = 3'd0,
        OP_TX_PUSH   = 3'd1,
        OP_TX_DONE   = 3'd2,
        OP_RX_ARRIVE = 3'd3,
        OP_RX_POP    = 3'd4
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_REJECT = 2'd1,
        ST_EMPTY  = 2'd2
    } status_t;

    // everything about one item except the ring byte itself
    typedef struct packed {
        status_t    status;
        logic       data_valid;
        logic       toward_line;
        logic       sel_tx;
        logic       fwd;
        logic [7:0] fwd_byte;
        logic [7:0] rx_count;
        logic       port_is_open;
        logic       tx_active;
    } resp_t;

endpackage

[rtl/core/mpsrb_ram.sv]
module mpsrb_ram
    import mpsrb_pkg::*;
#(
    parameter int WORDS = NUM_PORTS_DEF * TX_DEPTH_DEF,
    parameter int AW    = $clog2(WORDS)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [WORDS];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/core/mpsrb_ctrl.sv]
module mpsrb_ctrl
    import mpsrb_pkg::*;
#(
    parameter int NUM_PORTS = NUM_PORTS_DEF,
    parameter int RX_DEPTH  = RX_DEPTH_DEF,
    parameter int TX_DEPTH  = TX_DEPTH_DEF,
    parameter int TX_AW     = $clog2(NUM_PORTS * TX_DEPTH),
    parameter int RX_AW     = $clog2(NUM_PORTS * RX_DEPTH)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic [2:0]       opcode,
    input  logic [2:0]       port,
    input  logic [7:0]       data_in,
    input  logic             batch_end,
    output logic             tx_we,
    output logic [TX_AW-1:0] tx_waddr,
    output logic             tx_re,
    output logic [TX_AW-1:0] tx_raddr,
    output logic             rx_we,
    output logic [RX_AW-1:0] rx_waddr,
    output logic             rx_re,
    output logic [RX_AW-1:0] rx_raddr,
    output resp_t            resp
);

    localparam int PORT_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int TX_PW  = $clog2(TX_DEPTH);
    localparam int RX_PW  = $clog2(RX_DEPTH);
    localparam logic [TX_PW:0] TX_LIM = (TX_PW + 1)'(TX_DEPTH);
    localparam logic [RX_PW:0] RX_LIM = (RX_PW + 1)'(RX_DEPTH);

    logic [TX_PW-1:0] tx_wp_reg [NUM_PORTS];
    logic [TX_PW-1:0] tx_rp_reg [NUM_PORTS];
    logic [RX_PW-1:0] rx_wp_reg [NUM_PORTS];
    logic [RX_PW-1:0] rx_rp_reg [NUM_PORTS];
    logic [NUM_PORTS-1:0] open_reg;
    logic [NUM_PORTS-1:0] busy_reg;

    logic [PORT_W-1:0] pidx;
    logic              in_range;
    logic              upd;
    op_t               op;
    logic [TX_PW-1:0]  tx_wp, tx_rp, tx_wp_next, tx_rp_next, tx_rd_ptr;
    logic [RX_PW-1:0]  rx_wp, rx_rp, rx_wp_next, rx_rp_next;
    logic              open_c, busy_c, open_next, busy_next;
    logic              tx_wr, tx_rd, rx_wr, rx_rd;
    resp_t             r;

    function automatic logic [TX_PW-1:0] tx_inc(input logic [TX_PW-1:0] p);
        logic [TX_PW:0] s;
        s = {1'b0, p} + 1'b1;
        return (s >= TX_LIM) ? '0 : s[TX_PW-1:0];
    endfunction

    function automatic logic [RX_PW-1:0] rx_inc(input logic [RX_PW-1:0] p);
        logic [RX_PW:0] s;
        s = {1'b0, p} + 1'b1;
        return (s >= RX_LIM) ? '0 : s[RX_PW-1:0];
    endfunction

    function automatic logic [7:0] rx_held(input logic [RX_PW-1:0] w,
                                           input logic [RX_PW-1:0] rp);
        logic [RX_PW:0] d;
        if (w >= rp)
        begin
            d = {1'b0, w} - {1'b0, rp};
        end
        else
        begin
            d = {1'b0, w} + RX_LIM - {1'b0, rp};
        end
        return 8'(d);
    endfunction

    // addressed port state
    assign pidx     = PORT_W'(port);
    assign in_range = (32'(port) < NUM_PORTS);
    assign op       = op_t'(opcode);
    assign upd      = fire && in_range;
    assign tx_wp    = tx_wp_reg[pidx];
    assign tx_rp    = tx_rp_reg[pidx];
    assign rx_wp    = rx_wp_reg[pidx];
    assign rx_rp    = rx_rp_reg[pidx];
    assign open_c   = open_reg[pidx];
    assign busy_c   = busy_reg[pidx];

    // item decode and pointer update
    always_comb
    begin
        tx_wp_next = tx_wp;
        tx_rp_next = tx_rp;
        rx_wp_next = rx_wp;
        rx_rp_next = rx_rp;
        open_next  = open_c;
        busy_next  = busy_c;
        tx_rd_ptr  = tx_rp;
        tx_wr      = 1'b0;
        tx_rd      = 1'b0;
        rx_wr      = 1'b0;
        rx_rd      = 1'b0;
        r          = '0;
        r.status   = ST_OK;
        r.fwd_byte = data_in;
        case (op)
            OP_OPEN:
            begin
                if (open_c)
                begin
                    r.status = ST_REJECT;
                end
                else
                begin
                    tx_wp_next = '0;
                    tx_rp_next = '0;
                    rx_wp_next = '0;
                    rx_rp_next = '0;
                    busy_next  = 1'b0;
                    open_next  = 1'b1;
                end
            end
            OP_TX_PUSH:
            begin
                if (!open_c)
                begin
                    r.status = ST_REJECT;
                end
                else
                begin
                    tx_wr      = 1'b1;
                    tx_wp_next = tx_inc(tx_wp);
                    tx_rp_next = (tx_wp_next == tx_rp) ? tx_inc(tx_rp) : tx_rp;
                    if (batch_end && !busy_c)
                    begin
                        if (tx_wp_next != tx_rp_next)
                        begin
                            tx_rd        = 1'b1;
                            tx_rd_ptr    = tx_rp_next;
                            r.fwd        = (tx_rp_next == tx_wp);
                            tx_rp_next   = tx_inc(tx_rp_next);
                            r.data_valid = 1'b1;
                            r.toward_line = 1'b1;
                            r.sel_tx     = 1'b1;
                        end
                        busy_next = 1'b1;
                    end
                end
            end
            OP_TX_DONE:
            begin
                if (tx_wp == tx_rp)
                begin
                    busy_next = 1'b0;
                    r.status  = ST_EMPTY;
                end
                else
                begin
                    tx_rd         = 1'b1;
                    tx_rp_next    = tx_inc(tx_rp);
                    r.data_valid  = 1'b1;
                    r.toward_line = 1'b1;
                    r.sel_tx      = 1'b1;
                end
            end
            OP_RX_ARRIVE:
            begin
                rx_wr      = 1'b1;
                rx_wp_next = rx_inc(rx_wp);
                rx_rp_next = (rx_wp_next == rx_rp) ? rx_inc(rx_rp) : rx_rp;
            end
            OP_RX_POP:
            begin
                if (!open_c)
                begin
                    r.status = ST_REJECT;
                end
                else if (rx_wp == rx_rp)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    rx_rd        = 1'b1;
                    rx_rp_next   = rx_inc(rx_rp);
                    r.data_valid = 1'b1;
                end
            end
            default:
            begin
                r.status = ST_REJECT;
            end
        endcase
        r.rx_count     = open_next ? rx_held(rx_wp_next, rx_rp_next) : 8'd0;
        r.port_is_open = open_next;
        r.tx_active    = busy_next;
        if (!in_range)
        begin
            r        = '0;
            r.status = ST_REJECT;
        end
    end

    assign resp = r;

    // memory commands
    assign tx_we    = upd && tx_wr;
    assign tx_re    = upd && tx_rd;
    assign rx_we    = upd && rx_wr;
    assign rx_re    = upd && rx_rd;
    assign tx_waddr = TX_AW'(pidx) * TX_AW'(TX_DEPTH) + TX_AW'(tx_wp);
    assign tx_raddr = TX_AW'(pidx) * TX_AW'(TX_DEPTH) + TX_AW'(tx_rd_ptr);
    assign rx_waddr = RX_AW'(pidx) * RX_AW'(RX_DEPTH) + RX_AW'(rx_wp);
    assign rx_raddr = RX_AW'(pidx) * RX_AW'(RX_DEPTH) + RX_AW'(rx_rp);

    // per-port pointers and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PORTS; i++)
            begin
                tx_wp_reg[i] <= '0;
                tx_rp_reg[i] <= '0;
                rx_wp_reg[i] <= '0;
                rx_rp_reg[i] <= '0;
            end
            open_reg <= '0;
            busy_reg <= '0;
        end
        else if (upd)
        begin
            tx_wp_reg[pidx] <= tx_wp_next;
            tx_rp_reg[pidx] <= tx_rp_next;
            rx_wp_reg[pidx] <= rx_wp_next;
            rx_rp_reg[pidx] <= rx_rp_next;
            open_reg[pidx]  <= open_next;
            busy_reg[pidx]  <= busy_next;
        end
    end

endmodule

[rtl/core/multi_port_serial_ring_buffers.sv]
// path: an accepted item passes the read stage and then the output register
// throughput: one item per cycle unless out_ready stalls; pointers and flags
// update at the accept edge, the ring byte comes from a registered memory read
// reset: asynchronous, clears pointers, open and busy flags and pipeline valids;
// ring memories are not cleared and need no clearing pass
module multi_port_serial_ring_buffers
    import mpsrb_pkg::*;
#(
    parameter int NUM_PORTS = NUM_PORTS_DEF,
    parameter int RX_DEPTH  = RX_DEPTH_DEF,
    parameter int TX_DEPTH  = TX_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] opcode,
    input  logic [2:0] port,
    input  logic [7:0] data_in,
    input  logic       batch_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic [7:0] data_out,
    output logic       data_valid,
    output logic       data_toward_line,
    output logic [7:0] rx_count,
    output logic       port_is_open,
    output logic       tx_active
);

    localparam int TX_WORDS = NUM_PORTS * TX_DEPTH;
    localparam int RX_WORDS = NUM_PORTS * RX_DEPTH;
    localparam int TX_AW    = $clog2(TX_WORDS);
    localparam int RX_AW    = $clog2(RX_WORDS);

    logic             fire;
    logic             tx_we, tx_re, rx_we, rx_re;
    logic [TX_AW-1:0] tx_waddr, tx_raddr;
    logic [RX_AW-1:0] rx_waddr, rx_raddr;
    logic [7:0]       tx_q, rx_q;
    logic [7:0]       byte_sel;
    resp_t            resp;

    logic             s1_valid_reg;
    resp_t            s1_reg;
    logic             s1_adv;
    logic             out_valid_reg;
    logic [1:0]       status_reg;
    logic [7:0]       data_out_reg;
    logic             data_valid_reg;
    logic             toward_reg;
    logic [7:0]       rx_count_reg;
    logic             open_out_reg;
    logic             busy_out_reg;

    // handshake
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign fire     = in_valid && in_ready;

    mpsrb_ctrl #(
        .NUM_PORTS (NUM_PORTS),
        .RX_DEPTH  (RX_DEPTH),
        .TX_DEPTH  (TX_DEPTH),
        .TX_AW     (TX_AW),
        .RX_AW     (RX_AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .opcode    (opcode),
        .port      (port),
        .data_in   (data_in),
        .batch_end (batch_end),
        .tx_we     (tx_we),
        .tx_waddr  (tx_waddr),
        .tx_re     (tx_re),
        .tx_raddr  (tx_raddr),
        .rx_we     (rx_we),
        .rx_waddr  (rx_waddr),
        .rx_re     (rx_re),
        .rx_raddr  (rx_raddr),
        .resp      (resp)
    );

    mpsrb_ram #(
        .WORDS (TX_WORDS),
        .AW    (TX_AW)
    ) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_waddr),
        .wdata (data_in),
        .re    (tx_re),
        .raddr (tx_raddr),
        .rdata (tx_q)
    );

    mpsrb_ram #(
        .WORDS (RX_WORDS),
        .AW    (RX_AW)
    ) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_waddr),
        .wdata (data_in),
        .re    (rx_re),
        .raddr (rx_raddr),
        .rdata (rx_q)
    );

    // read stage: item info waits alongside the memory read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            s1_reg <= resp;
        end
    end

    // byte pick, with forwarding of a byte written in the same beat
    always_comb
    begin
        if (!s1_reg.data_valid)
        begin
            byte_sel = 8'd0;
        end
        else if (s1_reg.fwd)
        begin
            byte_sel = s1_reg.fwd_byte;
        end
        else if (s1_reg.sel_tx)
        begin
            byte_sel = tx_q;
        end
        else
        begin
            byte_sel = rx_q;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            status_reg     <= s1_reg.status;
            data_out_reg   <= byte_sel;
            data_valid_reg <= s1_reg.data_valid;
            toward_reg     <= s1_reg.toward_line;
            rx_count_reg   <= s1_reg.rx_count;
            open_out_reg   <= s1_reg.port_is_open;
            busy_out_reg   <= s1_reg.tx_active;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign data_out         = data_out_reg;
    assign data_valid       = data_valid_reg;
    assign data_toward_line = toward_reg;
    assign rx_count         = rx_count_reg;
    assign port_is_open     = open_out_reg;
    assign tx_active        = busy_out_reg;

endmodule
